/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/hti_pkg.sv */
package hti_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int HEXA_COUNT   = 1024;
    localparam int CORNERS      = 8;
    localparam int SLOT_COUNT   = HEXA_COUNT * CORNERS;
    localparam int VA_W         = $clog2(VERTEX_DEPTH);
    localparam int SA_W         = $clog2(SLOT_COUNT);
    localparam int K_W          = $clog2(CORNERS);

    localparam int CMD_W        = 2;
    localparam int ADDR_W       = 13;
    localparam int COORD_W      = 32;
    localparam int VERT_W       = 3 * COORD_W;
    localparam int CV_W         = 12;
    localparam int WGT_W        = 16;
    localparam int TAG_W        = 16;
    localparam int IN_DATA_W    = 192;
    localparam int OUT_DATA_W   = 112;

    // Shape-function arithmetic
    localparam int FACT_W       = WGT_W + 2;
    localparam int FAB_W        = 2 * FACT_W;
    localparam int WPROD_W      = FAB_W + FACT_W;
    localparam int CW_W         = 29;
    localparam int PROD_W       = COORD_W + CW_W;
    localparam int ACC_W        = 64;
    localparam int ONE_Q12      = 4096;
    localparam int CW_SHIFT     = 18;
    localparam int RES_SHIFT    = 21;

    localparam logic signed [FACT_W-1:0]  ONE_F   = FACT_W'(ONE_Q12);
    localparam logic signed [WPROD_W-1:0] CW_HALF = WPROD_W'(1) <<< (CW_SHIFT - 1);
    localparam logic signed [ACC_W-1:0]   RES_HALF = ACC_W'(1) <<< (RES_SHIFT - 1);
    localparam logic signed [ACC_W-1:0]   SAT_HI  =
        (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0]   SAT_LO  = ~SAT_HI;

    // Corner signs, bit k for corner k: 1 means (1 + w), 0 means (1 - w)
    localparam logic [CORNERS-1:0] SIGN_A = 8'b0110_0110;
    localparam logic [CORNERS-1:0] SIGN_B = 8'b1100_1100;
    localparam logic [CORNERS-1:0] SIGN_C = 8'b0000_1111;

    typedef enum logic [CMD_W-1:0] {
        CMD_VERTEX = 2'd0,
        CMD_CORNER = 2'd1,
        CMD_INTERP = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } hti_ctl_t;

endpackage

/* rtl/core/hti_ram.sv */
module hti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/hti_weight.sv */
module hti_weight
    import hti_pkg::*;
(
    input  logic                    clk,
    input  logic [K_W-1:0]          k,
    input  logic signed [WGT_W-1:0] wa,
    input  logic signed [WGT_W-1:0] wb,
    input  logic signed [WGT_W-1:0] wc,
    output logic signed [CW_W-1:0]  cw
);

    logic signed [FACT_W-1:0]  ext_a, ext_b, ext_c;
    logic signed [FACT_W-1:0]  fa, fb, fc;
    logic signed [FAB_W-1:0]   fab_reg;
    logic signed [FACT_W-1:0]  fc_reg;
    logic signed [WPROD_W-1:0] wfull;
    logic signed [WPROD_W-1:0] wround;
    logic signed [WPROD_W-1:0] wshift;
    logic signed [CW_W-1:0]    cw_reg;

    assign ext_a = FACT_W'(wa);
    assign ext_b = FACT_W'(wb);
    assign ext_c = FACT_W'(wc);

    assign fa = SIGN_A[k] ? ONE_F + ext_a : ONE_F - ext_a;
    assign fb = SIGN_B[k] ? ONE_F + ext_b : ONE_F - ext_b;
    assign fc = SIGN_C[k] ? ONE_F + ext_c : ONE_F - ext_c;

    // Fold the 1/8 into the rounding shift: Q.36 down to Q.21
    assign wfull  = fab_reg * fc_reg;
    assign wround = wfull + CW_HALF;
    assign wshift = wround >>> CW_SHIFT;

    always_ff @(posedge clk)
    begin
        fab_reg <= fa * fb;
        fc_reg  <= fc;
        cw_reg  <= CW_W'(wshift);
    end

    assign cw = cw_reg;

endmodule

/* rtl/core/hti_mac.sv */
module hti_mac
    import hti_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hti_ctl_t               ctl,
    input  logic [VERT_W-1:0]      vertex,
    input  logic signed [CW_W-1:0] cw,
    output logic [VERT_W-1:0]      res_vec,
    output logic                   res_sat,
    output logic                   done
);

    hti_ctl_t                  pctl_reg;
    logic                      done_reg;
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [ACC_W-1:0]   acc_reg  [3];
    logic signed [ACC_W-1:0]   sum      [3];
    logic signed [ACC_W-1:0]   rnd      [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pctl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pctl_reg <= ctl;
            done_reg <= pctl_reg.valid && pctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod_reg[j] <= $signed(vertex[j*COORD_W +: COORD_W]) * cw;
            if (pctl_reg.valid)
            begin
                // Restart the sum on the first corner
                acc_reg[j] <= (pctl_reg.first ? '0 : acc_reg[j]) + ACC_W'(prod_reg[j]);
            end
        end
    end

    always_comb
    begin
        res_sat = 1'b0;
        res_vec = '0;
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = acc_reg[j] + RES_HALF;
            rnd[j] = sum[j] >>> RES_SHIFT;
            if (rnd[j] > SAT_HI)
            begin
                res_vec[j*COORD_W +: COORD_W] = COORD_W'(SAT_HI);
                res_sat = 1'b1;
            end
            else if (rnd[j] < SAT_LO)
            begin
                res_vec[j*COORD_W +: COORD_W] = COORD_W'(SAT_LO);
                res_sat = 1'b1;
            end
            else
            begin
                res_vec[j*COORD_W +: COORD_W] = COORD_W'(rnd[j]);
            end
        end
    end

    assign done = done_reg;

endmodule

/* rtl/core/hexa_trilinear_interpolator.sv */
// Trilinear hexahedron interpolator.
// Input stream s_*: one beat per command. s_tuser carries the command: vertex write,
// corner write or interpolate. Writes go straight into the vertex or corner memory, give no
// output beat and leave the input ready. Out-of-range write addresses are dropped.
// An interpolate beat reads the eight corner slots of the named hexahedron, one a cycle,
// then the eight vertices behind them through a second memory, weights each corner by its
// trilinear shape function and sums. The result is registered once the sums are done and
// the output register is free; the input is ready again on the cycle the result is
// registered, so no new beat is taken while an interpolation runs through the eight
// single-port corner reads and the read, weight and accumulate pipeline behind them. A
// hexahedron number out of range skips the reads and gives a zero result.
// Output stream m_*: the result waits in an output register; while the receiver stalls,
// further writes are still taken and a following interpolation runs up to its result,
// then holds until the register drains.
// Reset clears the control state only; memory contents are undefined until written.
`include "assert_macros.svh"

module hexa_trilinear_interpolator
    import hti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // address, pos_x, pos_y, pos_z, corner_vertex, weight_a, weight_b, weight_c,
    // point_tag, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z, result_tag
    output logic [OUT_DATA_W-1:0] m_tdata,
    // saturated
    output logic [0:0]            m_tuser
);

    logic [ADDR_W-1:0]       in_address;
    logic [VERT_W-1:0]       in_pos;
    logic [CV_W-1:0]         in_corner_vertex;
    logic signed [WGT_W-1:0] in_wa, in_wb, in_wc;
    logic [TAG_W-1:0]        in_tag;
    cmd_t                    in_cmd;

    state_t                  state_reg, state_next;
    logic [K_W-1:0]          cnt_reg, cnt_next;
    logic                    null_reg, null_next;
    logic [ADDR_W-1:0]       hexa_reg;
    logic signed [WGT_W-1:0] wa_reg, wb_reg, wc_reg;
    logic [TAG_W-1:0]        tag_reg;

    logic                    s_fire;
    logic                    issue;
    logic                    out_load;
    logic                    out_free;
    logic                    hexa_ok;

    hti_ctl_t                ctl0;
    hti_ctl_t                ctl1_reg, ctl2_reg;
    logic                    vzero_reg;

    logic                    corner_we;
    logic [SA_W-1:0]         corner_addr;
    logic [CV_W-1:0]         corner_q;
    logic                    vertex_we;
    logic [VA_W-1:0]         vertex_addr;
    logic [VERT_W-1:0]       vertex_q;
    logic [VERT_W-1:0]       vertex_m;

    logic signed [CW_W-1:0]  cw;
    logic [VERT_W-1:0]       res_vec;
    logic                    res_sat;
    logic                    acc_done;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    m_tuser_reg;

    assign in_address       = s_tdata[12:0];
    assign in_pos           = s_tdata[108:13];
    assign in_corner_vertex = s_tdata[120:109];
    assign in_wa            = s_tdata[136:121];
    assign in_wb            = s_tdata[152:137];
    assign in_wc            = s_tdata[168:153];
    assign in_tag           = s_tdata[184:169];
    assign in_cmd           = cmd_t'(s_tuser);

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign hexa_ok  = 32'(in_address) < 32'(HEXA_COUNT);

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && in_cmd == CMD_INTERP)
                begin
                    state_next = hexa_ok ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == K_W'(CORNERS - 1))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (acc_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_RUN:    issue    = 1'b1;
            ST_WAIT:   ;
            ST_FINISH: out_load = out_free;
            default:   ;
        endcase
    end

    assign cnt_next  = issue ? cnt_reg + K_W'(1) : '0;
    assign null_next = (s_fire && in_cmd == CMD_INTERP) ? !hexa_ok : null_reg;

    assign ctl0.valid = issue;
    assign ctl0.first = cnt_reg == '0;
    assign ctl0.last  = cnt_reg == K_W'(CORNERS - 1);

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            null_reg     <= 1'b0;
            ctl1_reg     <= '0;
            ctl2_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            null_reg     <= null_next;
            ctl1_reg     <= ctl0;
            ctl2_reg     <= ctl1_reg;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the item's operands for the whole run
    always_ff @(posedge clk)
    begin
        if (s_fire && in_cmd == CMD_INTERP)
        begin
            hexa_reg <= in_address;
            wa_reg   <= in_wa;
            wb_reg   <= in_wb;
            wc_reg   <= in_wc;
            tag_reg  <= in_tag;
        end
        // Corners naming a vertex past the store count as zero
        vzero_reg <= 32'(corner_q) >= 32'(VERTEX_DEPTH);
        if (out_load)
        begin
            m_tdata_reg <= null_reg ? {tag_reg, {VERT_W{1'b0}}} : {tag_reg, res_vec};
            m_tuser_reg <= null_reg ? 1'b0 : res_sat;
        end
    end

    // ---------------------------------------------------------------- memories
    assign corner_we   = s_fire && in_cmd == CMD_CORNER
                         && 32'(in_address) < 32'(SLOT_COUNT);
    assign corner_addr = (state_reg == ST_IDLE) ? SA_W'(in_address)
                                                : SA_W'({hexa_reg, cnt_reg});
    assign vertex_we   = s_fire && in_cmd == CMD_VERTEX
                         && 32'(in_address) < 32'(VERTEX_DEPTH);
    assign vertex_addr = (state_reg == ST_IDLE) ? VA_W'(in_address) : VA_W'(corner_q);

    hti_ram #(
        .WIDTH (CV_W),
        .DEPTH (SLOT_COUNT)
    ) u_corner_ram (
        .clk   (clk),
        .we    (corner_we),
        .addr  (corner_addr),
        .wdata (in_corner_vertex),
        .rdata (corner_q)
    );

    hti_ram #(
        .WIDTH (VERT_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (vertex_we),
        .addr  (vertex_addr),
        .wdata (in_pos),
        .rdata (vertex_q)
    );

    assign vertex_m = vzero_reg ? '0 : vertex_q;

    // ---------------------------------------------------------------- datapath
    hti_weight u_weight (
        .clk (clk),
        .k   (cnt_reg),
        .wa  (wa_reg),
        .wb  (wb_reg),
        .wc  (wc_reg),
        .cw  (cw)
    );

    hti_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl2_reg),
        .vertex  (vertex_m),
        .cw      (cw),
        .res_vec (res_vec),
        .res_sat (res_sat),
        .done    (acc_done)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------- checks
    `ASSERT_IMPLY(a_done_in_wait, clk, rst_n, acc_done, state_reg == ST_WAIT)
    `ASSERT_IMPLY(a_pipe_in_run, clk, rst_n, ctl2_reg.valid, state_reg == ST_RUN || state_reg == ST_WAIT)
    `ASSERT_NEXT(a_run_to_wait, clk, rst_n, state_reg == ST_RUN && cnt_reg == K_W'(CORNERS - 1), state_reg == ST_WAIT)
    `ASSERT_IMPLY(a_beat_from_finish, clk, rst_n, $rose(m_tvalid_reg), $past(state_reg == ST_FINISH))

endmodule

/* tb/hexa_trilinear_interpolator_test.sv */
module hexa_trilinear_interpolator_test;
    import hti_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 32;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int MAX_PRINTED     = 50;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam longint Q12_ONE   = 4096;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    // bit k set: corner k takes (1 + w) on that axis
    localparam bit [CORNERS-1:0] PLUS_A = 8'b0110_0110;
    localparam bit [CORNERS-1:0] PLUS_B = 8'b1100_1100;
    localparam bit [CORNERS-1:0] PLUS_C = 8'b0000_1111;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TAG_W-1:0]          tag;
        logic                      sat;
    } point_t;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [ADDR_W-1:0]         addr;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [CV_W-1:0]           cv;
        logic signed [WGT_W-1:0]   wa;
        logic signed [WGT_W-1:0]   wb;
        logic signed [WGT_W-1:0]   wc;
        logic [TAG_W-1:0]          tag;
        logic                      has_exp;
        point_t                    exp_pt;
    } command_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;

    logic signed [COORD_W-1:0] vertex_mem [VERTEX_DEPTH][3];
    logic [CV_W-1:0]           corner_mem [SLOT_COUNT];
    bit                        vertex_known [VERTEX_DEPTH];
    bit                        slot_known [SLOT_COUNT];
    int                        vertex_list [$];
    int                        hexa_pool [$];
    point_t                    expected_points [$];

    int mismatches = 0;
    int effective_items = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    bit pressure_go = 1'b0;
    bit receiver_hold = 1'b0;

    hexa_trilinear_interpolator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] point,
                                   input logic [COORD_W-1:0] got,
                                   input logic [COORD_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("mismatch on %s, point %0d: got %h, want %h", what, point, got, want);
        end
    endtask

    function automatic point_t interpolate_point(input logic [ADDR_W-1:0] hexa,
                                                 input logic signed [WGT_W-1:0] wa,
                                                 input logic signed [WGT_W-1:0] wb,
                                                 input logic signed [WGT_W-1:0] wc,
                                                 input logic [TAG_W-1:0] tag);
        point_t                    res;
        longint                    acc [3];
        logic signed [COORD_W-1:0] coord [3];
        longint                    fa, fb, fc, wk, r;
        int                        vn;
        res = '0;
        res.tag = tag;
        for (int j = 0; j < 3; j++)
        begin
            acc[j] = 0;
            coord[j] = '0;
        end
        if (hexa < HEXA_COUNT)
        begin
            for (int k = 0; k < CORNERS; k++)
            begin
                vn = int'(corner_mem[hexa * CORNERS + k]);
                fa = PLUS_A[k] ? Q12_ONE + longint'(wa) : Q12_ONE - longint'(wa);
                fb = PLUS_B[k] ? Q12_ONE + longint'(wb) : Q12_ONE - longint'(wb);
                fc = PLUS_C[k] ? Q12_ONE + longint'(wc) : Q12_ONE - longint'(wc);
                // fold the one-eighth into the corner weight, round half up to Q.21
                wk = (fa * fb * fc + (64'sd1 <<< 17)) >>> 18;
                if (vn < VERTEX_DEPTH)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        acc[j] += longint'(vertex_mem[vn][j]) * wk;
                    end
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                r = (acc[j] + (64'sd1 <<< 20)) >>> 21;
                if (r > COORD_MAX)
                begin
                    r = COORD_MAX;
                    res.sat = 1'b1;
                end
                if (r < COORD_MIN)
                begin
                    r = COORD_MIN;
                    res.sat = 1'b1;
                end
                coord[j] = r[COORD_W-1:0];
            end
        end
        res.x = coord[0];
        res.y = coord[1];
        res.z = coord[2];
        return res;
    endfunction

    // Update the stores and queue the expected point for one accepted beat
    task automatic commit_command(input command_t c);
        case (c.cmd)
            CMD_VERTEX:
            begin
                if (c.addr < VERTEX_DEPTH)
                begin
                    vertex_mem[c.addr][0] = c.px;
                    vertex_mem[c.addr][1] = c.py;
                    vertex_mem[c.addr][2] = c.pz;
                    if (!vertex_known[c.addr])
                    begin
                        vertex_known[c.addr] = 1'b1;
                        vertex_list = {vertex_list, int'(c.addr)};
                    end
                    effective_items++;
                end
            end
            CMD_CORNER:
            begin
                if (c.addr < SLOT_COUNT)
                begin
                    corner_mem[c.addr] = c.cv;
                    slot_known[c.addr] = 1'b1;
                    effective_items++;
                end
            end
            CMD_INTERP:
            begin
                if (c.has_exp)
                begin
                    expected_points = {expected_points, c.exp_pt};
                end
                else
                begin
                    expected_points = {expected_points,
                                       interpolate_point(c.addr, c.wa, c.wb, c.wc, c.tag)};
                end
                effective_items++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_command(input command_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= IN_DATA_W'({c.tag, c.wc, c.wb, c.wa, c.cv, c.pz, c.py, c.px, c.addr});
        do
            @(posedge clk);
        while (!s_tready);
        commit_command(c);
    endtask

    function automatic command_t random_command(input logic [CMD_W-1:0] cmd);
        command_t c;
        c.cmd     = cmd;
        c.addr    = ADDR_W'($urandom);
        c.px      = COORD_W'($urandom);
        c.py      = COORD_W'($urandom);
        c.pz      = COORD_W'($urandom);
        c.cv      = CV_W'($urandom);
        c.wa      = WGT_W'($urandom);
        c.wb      = WGT_W'($urandom);
        c.wc      = WGT_W'($urandom);
        c.tag     = TAG_W'($urandom);
        c.has_exp = 1'b0;
        c.exp_pt  = '0;
        return c;
    endfunction

    function automatic command_t mk(input logic [CMD_W-1:0] cmd, input int addr,
                                    input logic [COORD_W-1:0] px,
                                    input logic [COORD_W-1:0] py,
                                    input logic [COORD_W-1:0] pz, input int cv,
                                    input logic [WGT_W-1:0] wa, input logic [WGT_W-1:0] wb,
                                    input logic [WGT_W-1:0] wc, input logic [TAG_W-1:0] tag);
        command_t c;
        c.cmd     = cmd;
        c.addr    = ADDR_W'(addr);
        c.px      = px;
        c.py      = py;
        c.pz      = pz;
        c.cv      = CV_W'(cv);
        c.wa      = wa;
        c.wb      = wb;
        c.wc      = wc;
        c.tag     = tag;
        c.has_exp = 1'b0;
        c.exp_pt  = '0;
        return c;
    endfunction

    function automatic command_t with_expect(input command_t c,
                                             input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] z);
        c.has_exp    = 1'b1;
        c.exp_pt.x   = x;
        c.exp_pt.y   = y;
        c.exp_pt.z   = z;
        c.exp_pt.tag = c.tag;
        c.exp_pt.sat = 1'b0;
        return c;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return COORD_W'($urandom);
        if (pick < 85)
            return COORD_W'(int'($urandom_range(2097152)) - 1048576);
        case ($urandom_range(3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [WGT_W-1:0] rand_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return WGT_W'(int'($urandom_range(8192)) - 4096);
        if (pick < 75)
            return WGT_W'($urandom);
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd4096;
            3: return 16'sd4096;
            default: return '0;
        endcase
    endfunction

    // A hexahedron may be interpolated only once all eight slots and their vertices exist
    function automatic bit hexa_ready(input int h);
        bit ok;
        ok = 1'b1;
        for (int k = 0; k < CORNERS; k++)
        begin
            if (!slot_known[h * CORNERS + k] ||
                !vertex_known[corner_mem[h * CORNERS + k]])
                ok = 1'b0;
        end
        return ok;
    endfunction

    task automatic interpolate_burst(input int h, input int n);
        command_t c;
        repeat (n)
        begin
            c = random_command(CMD_INTERP);
            c.addr = ADDR_W'(h);
            c.wa = rand_weight();
            c.wb = rand_weight();
            c.wc = rand_weight();
            send_command(c);
        end
    endtask

    task automatic run_traffic(input int idle, input int stall, input int items,
                               input bit squeeze);
        command_t c;
        int       start;
        int       pick;
        int       h;
        start = effective_items;
        send_idle_pct = idle;
        stall_pct = stall;
        while (effective_items - start < items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // fresh vertices, a full corner set, then some interpolated points on it
                if ($urandom_range(19) == 0)
                    h = $urandom_range(1) ? HEXA_COUNT - 1 : 0;
                else
                    h = $urandom_range(HEXA_COUNT - 1);
                repeat ($urandom_range(3, 1))
                begin
                    c = random_command(CMD_VERTEX);
                    c.addr = ADDR_W'($urandom_range(VERTEX_DEPTH - 1));
                    c.px = rand_coord();
                    c.py = rand_coord();
                    c.pz = rand_coord();
                    send_command(c);
                end
                for (int k = 0; k < CORNERS; k++)
                begin
                    c = random_command(CMD_CORNER);
                    c.addr = ADDR_W'(h * CORNERS + k);
                    c.cv = CV_W'(vertex_list[$urandom_range(vertex_list.size() - 1)]);
                    send_command(c);
                end
                hexa_pool = {hexa_pool, h};
                interpolate_burst(h, $urandom_range(3, 1));
            end
            else if (pick < 82)
            begin
                h = hexa_pool[$urandom_range(hexa_pool.size() - 1)];
                if (hexa_ready(h))
                    interpolate_burst(h, $urandom_range(4, 1));
            end
            else
            begin
                case ($urandom_range(4))
                    0:
                    begin
                        send_command(random_command(CMD_UNUSED));
                    end
                    1:
                    begin
                        c = random_command(CMD_VERTEX);
                        c.addr = ADDR_W'($urandom_range(8191, VERTEX_DEPTH));
                        send_command(c);
                    end
                    2:
                    begin
                        interpolate_burst($urandom_range(8191, HEXA_COUNT), 1);
                    end
                    3:
                    begin
                        // may leave a hexahedron pointing at an unwritten vertex
                        c = random_command(CMD_CORNER);
                        send_command(c);
                    end
                    default:
                    begin
                        c = random_command(CMD_VERTEX);
                        c.addr = ADDR_W'($urandom_range(VERTEX_DEPTH - 1));
                        send_command(c);
                    end
                endcase
            end
            if (squeeze && !pressure_go && effective_items - start > items / 2)
            begin
                pressure_go = 1'b1;
                h = hexa_pool[$urandom_range(hexa_pool.size() - 1)];
                interpolate_burst(hexa_ready(h) ? h : HEXA_COUNT, 24);
            end
        end
    endtask

    always @(posedge clk)
    begin
        m_tready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
    end

    // Long receiver hold-off: the block must fill up and stall its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        point_t got;
        point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x   = m_tdata[COORD_W-1:0];
            got.y   = m_tdata[2*COORD_W-1:COORD_W];
            got.z   = m_tdata[3*COORD_W-1:2*COORD_W];
            got.tag = m_tdata[3*COORD_W+TAG_W-1:3*COORD_W];
            got.sat = m_tuser[0];
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected beat", got.tag, got.x, '0);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got.x !== want.x)
                    report_mismatch("out_x", want.tag, got.x, want.x);
                if (got.y !== want.y)
                    report_mismatch("out_y", want.tag, got.y, want.y);
                if (got.z !== want.z)
                    report_mismatch("out_z", want.tag, got.z, want.z);
                if (got.tag !== want.tag)
                    report_mismatch("result_tag", want.tag, COORD_W'(got.tag),
                                    COORD_W'(want.tag));
                if (got.sat !== want.sat)
                    report_mismatch("saturated", want.tag, COORD_W'(got.sat),
                                    COORD_W'(want.sat));
            end
        end
    end

    initial
    begin
        command_t directed [$];
        directed = {directed, mk(CMD_VERTEX, 0, 32'sh0001_0000, -32'sh0002_0000,
                                 32'sh0003_0000, 0, '0, '0, '0, '0)};
        directed = {directed, mk(CMD_VERTEX, 1, -32'sh0005_0000, 32'sh0007_8000,
                                 32'sh0000_0001, 0, '0, '0, '0, '0)};
        directed = {directed, mk(CMD_VERTEX, VERTEX_DEPTH - 1, 32'sh7FFF_FFFF,
                                 32'sh8000_0000, '1, 0, '0, '0, '0, '0)};
        // out of range vertex and unknown command: both dropped
        directed = {directed, mk(CMD_VERTEX, 8191, '1, '1, '1, 4095, '1, '1, '1, '1)};
        directed = {directed, mk(CMD_UNUSED, 8191, '1, '1, '1, 4095, '1, '1, '1, '1)};
        for (int k = 0; k < CORNERS; k++)
        begin
            directed = {directed, mk(CMD_CORNER, k, '0, '0, '0,
                                     (k == 2) ? 1 : (k == 4) ? VERTEX_DEPTH - 1 : 0,
                                     '0, '0, '0, '0)};
        end
        directed = {directed, mk(CMD_CORNER, SLOT_COUNT - 1, '0, '0, '0,
                                 VERTEX_DEPTH - 1, '0, '0, '0, '0)};
        // weights at plus one pick corner two alone, at minus one corner four alone
        directed = {directed, with_expect(mk(CMD_INTERP, 0, '0, '0, '0, 0, 16'sd4096,
                                             16'sd4096, 16'sd4096, 16'hFFFF),
                                          -32'sh0005_0000, 32'sh0007_8000,
                                          32'sh0000_0001)};
        directed = {directed, with_expect(mk(CMD_INTERP, 0, '0, '0, '0, 0, -16'sd4096,
                                             -16'sd4096, -16'sd4096, 16'h0000),
                                          32'sh7FFF_FFFF, 32'sh8000_0000, '1)};
        directed = {directed, mk(CMD_INTERP, 0, '0, '0, '0, 0, '0, '0, '0, 16'h0001)};
        directed = {directed, mk(CMD_INTERP, 0, '0, '0, '0, 0, 16'sh7FFF, 16'sh7FFF,
                                 16'sh7FFF, 16'h0002)};
        directed = {directed, mk(CMD_INTERP, 0, '0, '0, '0, 0, 16'sh8000, 16'sh8000,
                                 16'sh8000, 16'h0003)};
        directed = {directed, mk(CMD_INTERP, 0, '0, '0, '0, 0, 16'sh7FFF, 16'sh8000, '0,
                                 16'h0004)};
        // hexahedron out of range: zero point, tag echoed
        directed = {directed, with_expect(mk(CMD_INTERP, 8191, '1, '1, '1, 4095, '1, '1,
                                             '1, 16'h1234), '0, '0, '0)};
        directed = {directed, with_expect(mk(CMD_INTERP, HEXA_COUNT, '0, '0, '0, 0, '0,
                                             '0, '0, 16'hABCD), '0, '0, '0)};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_command(directed[i]);
        end
        hexa_pool = {hexa_pool, 0};

        run_traffic(0, 0, ITEMS_PER_PHASE, 1'b1);
        run_traffic(65, 0, ITEMS_PER_PHASE, 1'b0);
        run_traffic(0, 65, ITEMS_PER_PHASE, 1'b0);
        run_traffic(36, 36, ITEMS_PER_PHASE, 1'b0);

        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
